### rtl/tcq_pkg.sv
// ----------------------------------------------------------------------------
// tcq_pkg
// Shared types and constants for the two-class age-ordered queue.
// ----------------------------------------------------------------------------
package tcq_pkg;

  localparam int unsigned DEPTH_DEF = 512;

  // command codes
  localparam logic [1:0] CMD_ENQ = 2'd0;
  localparam logic [1:0] CMD_ANY = 2'd1;
  localparam logic [1:0] CMD_POS = 2'd2;
  localparam logic [1:0] CMD_NEG = 2'd3;

  localparam logic signed [7:0] VAL_MAX = 8'sd100;
  localparam logic signed [7:0] VAL_MIN = -8'sd100;

  // datapath commands from the controller
  typedef struct packed {
    logic load;       // latch command and value
    logic rd_head;    // capture the selected slot for the memory reads
    logic enq_wr;     // perform enqueue writes
    logic deq_wr;     // perform dequeue writes
    logic emit;       // present result
  } tcq_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic is_enq;
    logic enq_ok;
    logic deq_ok;
  } tcq_stat_t;

endpackage

### rtl/tcq_ctrl.sv
// ----------------------------------------------------------------------------
// tcq_ctrl
// Sequencer: load, address read, data read, write back.
// ----------------------------------------------------------------------------
module tcq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tcq_pkg::tcq_stat_t stat,
  output tcq_pkg::tcq_cmd_t  cmd
);
  import tcq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_WR   = 2'd3;

  logic [1:0] state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_WR;
      ST_WR:   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // command decode
  always_comb begin
    cmd         = '0;
    cmd.load    = (state_r == ST_IDLE) && start;
    cmd.rd_head = (state_r == ST_RD);
    cmd.enq_wr  = (state_r == ST_WR) && stat.is_enq && stat.enq_ok;
    cmd.deq_wr  = (state_r == ST_WR) && !stat.is_enq && stat.deq_ok;
    cmd.emit    = cmd.deq_wr;
  end

  assign busy = (state_r != ST_IDLE);
endmodule

### rtl/tcq_dp.sv
// ----------------------------------------------------------------------------
// tcq_dp
// Slot memories, list pointers and entry count.
// ----------------------------------------------------------------------------
module tcq_dp #(
  parameter int unsigned DEPTH = tcq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_command,
  input  logic signed [7:0] in_value,
  input  tcq_pkg::tcq_cmd_t  cmd,
  output tcq_pkg::tcq_stat_t stat,
  output logic              out_valid,
  output logic signed [7:0] out_taken_value
);
  import tcq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] NIL = PW'(DEPTH);

  // slot memories
  logic signed [7:0] val_mem [DEPTH];
  logic [PW-1:0] onext_mem [DEPTH];
  logic [PW-1:0] oprev_mem [DEPTH];
  logic [PW-1:0] cnext_mem [DEPTH];
  logic [PW-1:0] free_mem  [DEPTH];

  logic [1:0]        op_r;
  logic signed [7:0] v_r;
  logic [PW-1:0] oh_r, ot_r, ph_r, pt_r, nh_r, nt_r, fh_r;
  logic [PW-1:0] fill_r;   // slots never used yet
  logic [PW-1:0] cnt_r;
  logic [PW-1:0] s_r;
  logic signed [7:0] rv_r;
  logic [PW-1:0] rn_r, rp_r, rc_r, rf_r;
  logic out_valid_r;
  logic signed [7:0] out_r;

  // slot choice
  logic [PW-1:0] sel;
  logic          use_fill;
  always_comb begin
    use_fill = (fh_r == NIL);
    unique case (op_r)
      CMD_ENQ: sel = use_fill ? fill_r : fh_r;
      CMD_ANY: sel = oh_r;
      CMD_POS: sel = ph_r;
      CMD_NEG: sel = nh_r;
      default: sel = oh_r;
    endcase
  end

  logic in_rng;
  assign in_rng = (v_r <= VAL_MAX) && (v_r >= VAL_MIN);
  assign stat.is_enq = (op_r == CMD_ENQ);
  assign stat.enq_ok = in_rng && (cnt_r < NIL);
  assign stat.deq_ok = (s_r != NIL);

  // latch command, capture selected slot
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_command;
      v_r  <= in_value;
    end
    if (cmd.rd_head) s_r <= sel;
  end

  // registered reads at selected slot
  logic [AW-1:0] ra;
  assign ra = s_r[AW-1:0];
  always_ff @(posedge clk) begin
    rv_r <= val_mem[ra];
    rn_r <= onext_mem[ra];
    rp_r <= oprev_mem[ra];
    rc_r <= cnext_mem[ra];
    rf_r <= free_mem[ra];
  end

  // dequeue class decision
  logic is_pos, is_neg;
  always_comb begin
    is_pos = (op_r == CMD_POS) || ((op_r == CMD_ANY) && (rv_r > 0));
    is_neg = (op_r == CMD_NEG) || ((op_r == CMD_ANY) && (rv_r < 0));
  end

  // memory writes
  logic [AW-1:0] sa;
  assign sa = s_r[AW-1:0];
  always_ff @(posedge clk) begin
    if (cmd.enq_wr) begin
      val_mem[sa]   <= v_r;
      onext_mem[sa] <= NIL;
      oprev_mem[sa] <= ot_r;
      cnext_mem[sa] <= NIL;
      if (ot_r != NIL) onext_mem[ot_r[AW-1:0]] <= s_r;
      if (v_r > 0 && pt_r != NIL) cnext_mem[pt_r[AW-1:0]] <= s_r;
      if (v_r < 0 && nt_r != NIL) cnext_mem[nt_r[AW-1:0]] <= s_r;
    end
    if (cmd.deq_wr) begin
      free_mem[sa] <= fh_r;
      if (rp_r != NIL) onext_mem[rp_r[AW-1:0]] <= rn_r;
      if (rn_r != NIL) oprev_mem[rn_r[AW-1:0]] <= rp_r;
    end
  end

  // list pointers and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oh_r <= NIL; ot_r <= NIL; ph_r <= NIL; pt_r <= NIL;
      nh_r <= NIL; nt_r <= NIL; fh_r <= NIL;
      fill_r <= '0; cnt_r <= '0; out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.enq_wr) begin
        if (s_r == fill_r && fh_r == NIL) fill_r <= fill_r + PW'(1);
        else fh_r <= rf_r;
        if (ot_r == NIL) oh_r <= s_r;
        ot_r <= s_r;
        if (v_r > 0) begin
          if (pt_r == NIL) ph_r <= s_r;
          pt_r <= s_r;
        end else if (v_r < 0) begin
          if (nt_r == NIL) nh_r <= s_r;
          nt_r <= s_r;
        end
        cnt_r <= cnt_r + PW'(1);
      end
      if (cmd.deq_wr) begin
        fh_r <= s_r;
        if (rp_r == NIL) oh_r <= rn_r;
        if (rn_r == NIL) ot_r <= rp_r;
        if (is_pos) begin
          ph_r <= rc_r;
          if (rc_r == NIL) pt_r <= NIL;
        end else if (is_neg) begin
          nh_r <= rc_r;
          if (rc_r == NIL) nt_r <= NIL;
        end
        cnt_r <= cnt_r - PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_r <= rv_r;
  end

  assign out_valid       = out_valid_r;
  assign out_taken_value = out_r;
endmodule

### rtl/two_class_age_ordered_queue_unit.sv
// ----------------------------------------------------------------------------
// two_class_age_ordered_queue_unit
// Arrival-ordered queue with positive and negative class lists.
// ----------------------------------------------------------------------------
// channel   ports                            handshake
// input     in_command, in_value             start high, busy low
// result    out_taken_value                  out_valid, one cycle
//
// each command steps through load, slot read, data read and write back, then the result is
// shown; the dependent slot read then link write sequence through the slot memories sets this.
// reset clears pointers, counts and out_valid only; unused slots come from a fill count.
// the result is shown for one cycle; the receiver cannot stall.
module two_class_age_ordered_queue_unit #(
  parameter int unsigned DEPTH = tcq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_command,
  input  logic signed [7:0] in_value,
  output logic              out_valid,
  output logic signed [7:0] out_taken_value
);
  import tcq_pkg::*;

  tcq_cmd_t  cmd;
  tcq_stat_t stat;

  // controller
  tcq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .stat(stat), .cmd(cmd)
  );

  // datapath
  tcq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_command(in_command), .in_value(in_value),
    .cmd(cmd), .stat(stat), .out_valid(out_valid),
    .out_taken_value(out_taken_value)
  );
endmodule
